// ----- hdl/decimal_accumulator_execute_unit_macros.svh -----
// Assertion macros shared by the execute unit RTL.
`ifndef DECIMAL_ACCUMULATOR_EXECUTE_UNIT_MACROS_SVH
`define DECIMAL_ACCUMULATOR_EXECUTE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DAEU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DAEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/daeu_pkg.sv -----
// Shared types, codes and widths of the decimal accumulator execute unit.
package daeu_pkg;

  localparam int MEM_WORDS_DEF = 100;

  localparam int CMD_W    = 7;
  localparam int ADDR_W   = 7;
  localparam int RV_W     = 16;
  localparam int WORD_W   = 15;
  localparam int MAG_W    = 14;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int STATUS_W = 3;
  localparam int TGT_W    = 7;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 15'sd9999;
  localparam logic signed [WORD_W-1:0] WORD_MIN = -15'sd9999;
  localparam logic signed [RV_W-1:0]   RV_MAX   = 16'sd9999;
  localparam logic signed [RV_W-1:0]   RV_MIN   = -16'sd9999;

  localparam logic [CMD_W-1:0] OP_READ   = 7'd10;
  localparam logic [CMD_W-1:0] OP_WRITE  = 7'd11;
  localparam logic [CMD_W-1:0] OP_LOAD   = 7'd20;
  localparam logic [CMD_W-1:0] OP_STORE  = 7'd21;
  localparam logic [CMD_W-1:0] OP_ADD    = 7'd30;
  localparam logic [CMD_W-1:0] OP_SUB    = 7'd31;
  localparam logic [CMD_W-1:0] OP_DIV    = 7'd32;
  localparam logic [CMD_W-1:0] OP_MUL    = 7'd33;
  localparam logic [CMD_W-1:0] OP_BR     = 7'd40;
  localparam logic [CMD_W-1:0] OP_BRNEG  = 7'd41;
  localparam logic [CMD_W-1:0] OP_BRZERO = 7'd42;
  localparam logic [CMD_W-1:0] OP_HALT   = 7'd43;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_HALT       = 3'd1,
    ST_READ_RANGE = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_DIV_ZERO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

endpackage

// ----- hdl/decimal_accumulator_execute_unit.sv -----
// Each item moves from the idle state to execute, then through wait for multiply and non-zero
// divide, and to done, where it waits for the output register to be free before its result beat.
// Multiply and divide run through a shared unit that takes one bit a cycle.
// The next item is taken once the previous result sits in the output register.
// Reset clears the accumulator and the valid bits of all memory words, so all words read
// as zero; reset takes effect at once with no clearing pass.
module decimal_accumulator_execute_unit #(
  parameter int MEM_WORDS = daeu_pkg::MEM_WORDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // cmd [6:0], address [13:7], read_value [29:14], zero fill [31:30]
  input  logic [daeu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status [2:0], write_valid [3], write_word [18:4], branch_taken [19],
  // branch_target [26:20], accumulator_out [41:27], zero fill [47:42]
  output logic [daeu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  `include "decimal_accumulator_execute_unit_macros.svh"

  localparam int CMD_W  = daeu_pkg::CMD_W;
  localparam int ADDR_W = daeu_pkg::ADDR_W;
  localparam int RV_W   = daeu_pkg::RV_W;
  localparam int WORD_W = daeu_pkg::WORD_W;
  localparam int MAG_W  = daeu_pkg::MAG_W;
  localparam int PROD_W = daeu_pkg::PROD_W;
  localparam int IDX_W  = $clog2(MEM_WORDS);
  localparam int FILL_W = daeu_pkg::OUT_TDATA_W - (daeu_pkg::STATUS_W + 1 + WORD_W + 1 +
                                                   daeu_pkg::TGT_W + WORD_W);

  daeu_pkg::state_t state;
  daeu_pkg::state_t state_next;

  logic                     accept;
  logic [CMD_W-1:0]         in_cmd;
  logic [ADDR_W-1:0]        in_addr;
  logic [RV_W-1:0]          in_rv;

  logic [CMD_W-1:0]         cmd_r;
  logic [ADDR_W-1:0]        addr_r;
  logic signed [RV_W-1:0]   rv_r;
  logic                     addr_ok_r;

  logic signed [WORD_W-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0]     mem_vld;
  logic signed [WORD_W-1:0] rd_word;
  logic                     rd_vld;
  logic signed [WORD_W-1:0] m_word;

  logic signed [WORD_W-1:0] acc;

  logic                     mem_we;
  logic signed [WORD_W-1:0] mem_wdata;
  logic                     acc_we;
  logic signed [WORD_W-1:0] acc_wdata;
  logic                     res_we;
  daeu_pkg::status_t        st_val;
  logic                     wvalid_val;
  logic signed [WORD_W-1:0] wword_val;
  logic                     btaken_val;

  daeu_pkg::status_t        res_status;
  logic                     res_wvalid;
  logic signed [WORD_W-1:0] res_wword;
  logic                     res_btaken;
  logic [ADDR_W-1:0]        res_btarget;
  logic signed [WORD_W-1:0] res_acc;

  logic signed [RV_W-1:0]   sum16;
  logic signed [WORD_W-1:0] acc_abs;
  logic signed [WORD_W-1:0] m_abs;
  logic                     neg;
  logic [PROD_W-1:0]        mdu_result;
  logic [WORD_W-1:0]        mag;
  daeu_pkg::mdu_ctl_t       mdu_ctl;
  daeu_pkg::mdu_rsp_t       mdu_rsp;
  logic                     out_free;

  assign in_cmd  = s_axis_tdata[CMD_W-1:0];
  assign in_addr = s_axis_tdata[CMD_W+ADDR_W-1:CMD_W];
  assign in_rv   = s_axis_tdata[CMD_W+ADDR_W+RV_W-1:CMD_W+ADDR_W];

  assign s_axis_tready = (state == daeu_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_cmd;
      addr_r    <= in_addr;
      rv_r      <= in_rv;
      addr_ok_r <= in_addr < ADDR_W'(MEM_WORDS);
      rd_word   <= mem[in_addr[IDX_W-1:0]];
      rd_vld    <= mem_vld[in_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r[IDX_W-1:0]] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
    end else if (mem_we) begin
      mem_vld[addr_r[IDX_W-1:0]] <= 1'b1;
    end
  end

  assign m_word  = (addr_ok_r && rd_vld) ? rd_word : '0;
  assign acc_abs = acc[WORD_W-1] ? -acc : acc;
  assign m_abs   = m_word[WORD_W-1] ? -m_word : m_word;
  assign neg     = acc[WORD_W-1] ^ m_word[WORD_W-1];
  assign sum16   = (cmd_r == daeu_pkg::OP_SUB) ?
                   {acc[WORD_W-1], acc} - {m_word[WORD_W-1], m_word} :
                   {acc[WORD_W-1], acc} + {m_word[WORD_W-1], m_word};

  daeu_mdu u_mdu (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mdu_ctl),
    .a      (m_abs[MAG_W-1:0]),
    .b      (acc_abs[MAG_W-1:0]),
    .rsp    (mdu_rsp),
    .result (mdu_result)
  );

  always_comb begin
    state_next = state;
    case (state)
      daeu_pkg::S_IDLE: begin
        if (accept) state_next = daeu_pkg::S_EXEC;
      end
      daeu_pkg::S_EXEC: begin
        state_next = mdu_ctl.start ? daeu_pkg::S_WAIT : daeu_pkg::S_DONE;
      end
      daeu_pkg::S_WAIT: begin
        if (mdu_rsp.done) state_next = daeu_pkg::S_DONE;
      end
      daeu_pkg::S_DONE: begin
        if (out_free) state_next = daeu_pkg::S_IDLE;
      end
      default: state_next = daeu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we         = 1'b0;
    mem_wdata      = acc;
    acc_we         = 1'b0;
    acc_wdata      = acc;
    res_we         = 1'b0;
    st_val         = daeu_pkg::ST_OK;
    wvalid_val     = 1'b0;
    wword_val      = '0;
    btaken_val     = 1'b0;
    mdu_ctl.start  = 1'b0;
    mdu_ctl.is_div = (cmd_r == daeu_pkg::OP_DIV);
    mag            = mdu_result[WORD_W-1:0];
    case (state)
      daeu_pkg::S_EXEC: begin
        res_we = 1'b1;
        case (cmd_r)
          daeu_pkg::OP_READ: begin
            if (rv_r >= daeu_pkg::RV_MIN && rv_r <= daeu_pkg::RV_MAX) begin
              mem_we    = addr_ok_r;
              mem_wdata = rv_r[WORD_W-1:0];
            end else begin
              st_val = daeu_pkg::ST_READ_RANGE;
            end
          end
          daeu_pkg::OP_WRITE: begin
            wvalid_val = 1'b1;
            wword_val  = m_word;
          end
          daeu_pkg::OP_LOAD: begin
            acc_we    = 1'b1;
            acc_wdata = m_word;
          end
          daeu_pkg::OP_STORE: begin
            mem_we = addr_ok_r;
          end
          daeu_pkg::OP_ADD, daeu_pkg::OP_SUB: begin
            if (sum16 >= daeu_pkg::RV_MIN && sum16 <= daeu_pkg::RV_MAX) begin
              acc_we    = 1'b1;
              acc_wdata = sum16[WORD_W-1:0];
            end else begin
              st_val = daeu_pkg::ST_OVERFLOW;
            end
          end
          daeu_pkg::OP_MUL: begin
            res_we        = 1'b0;
            mdu_ctl.start = 1'b1;
          end
          daeu_pkg::OP_DIV: begin
            if (acc == '0) begin
              st_val = daeu_pkg::ST_DIV_ZERO;
            end else begin
              res_we        = 1'b0;
              mdu_ctl.start = 1'b1;
            end
          end
          daeu_pkg::OP_BR:     btaken_val = 1'b1;
          daeu_pkg::OP_BRNEG:  btaken_val = acc[WORD_W-1];
          daeu_pkg::OP_BRZERO: btaken_val = (acc == '0);
          daeu_pkg::OP_HALT:   st_val = daeu_pkg::ST_HALT;
          default: ;
        endcase
      end
      daeu_pkg::S_WAIT: begin
        if (mdu_rsp.done) begin
          res_we = 1'b1;
          if (mdu_ctl.is_div || mdu_result <= PROD_W'(daeu_pkg::WORD_MAX)) begin
            acc_we    = 1'b1;
            acc_wdata = neg ? -mag : mag;
          end else begin
            st_val = daeu_pkg::ST_OVERFLOW;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= daeu_pkg::S_IDLE;
      acc   <= '0;
    end else begin
      state <= state_next;
      if (acc_we) acc <= acc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_status  <= st_val;
      res_wvalid  <= wvalid_val;
      res_wword   <= wword_val;
      res_btaken  <= btaken_val;
      res_btarget <= btaken_val ? addr_r : '0;
      res_acc     <= acc_we ? acc_wdata : acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == daeu_pkg::S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == daeu_pkg::S_DONE && out_free) begin
      m_axis_tdata <= {{FILL_W{1'b0}}, res_acc, res_btarget, res_btaken, res_wword,
                       res_wvalid, res_status};
    end
  end

  `DAEU_ASSERT_NOW(a_acc_range, clk, rst, 1'b1,
                   (acc >= daeu_pkg::WORD_MIN) && (acc <= daeu_pkg::WORD_MAX),
                   "accumulator outside the four-digit range")
  `DAEU_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == daeu_pkg::S_EXEC,
                    "accepted beat did not move to execute")
  `DAEU_ASSERT_NOW(a_mdu_done_wait, clk, rst, mdu_rsp.done, state == daeu_pkg::S_WAIT,
                   "shared unit finished outside the wait state")
  `DAEU_ASSERT_NOW(a_out_from_done, clk, rst, $rose(m_axis_tvalid),
                   $past(state) == daeu_pkg::S_DONE,
                   "result beat raised without a finished instruction")

endmodule

// ----- hdl/daeu_mdu.sv -----
// Shared iterative unit: shift-add multiply and restoring divide of magnitudes.
module daeu_mdu (
  input  logic                         clk,
  input  logic                         rst,
  input  daeu_pkg::mdu_ctl_t           ctl,
  input  logic [daeu_pkg::MAG_W-1:0]   a,
  input  logic [daeu_pkg::MAG_W-1:0]   b,
  output daeu_pkg::mdu_rsp_t           rsp,
  output logic [daeu_pkg::PROD_W-1:0]  result
);

  localparam int MAG_W  = daeu_pkg::MAG_W;
  localparam int PROD_W = daeu_pkg::PROD_W;
  localparam int CNT_W  = $clog2(MAG_W);

  logic              busy;
  logic              done;
  logic              is_div;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] sh_r;
  logic [MAG_W-1:0]  q_r;

  logic [PROD_W-1:0] op_a;
  logic [PROD_W-1:0] op_b;
  logic [PROD_W:0]   sum;

  always_comb begin
    if (is_div) begin
      op_a = {{(PROD_W-MAG_W-1){1'b0}}, acc_r[MAG_W-1:0], q_r[MAG_W-1]};
      op_b = sh_r;
      sum  = {1'b0, op_a} - {1'b0, op_b};
    end else begin
      op_a = acc_r;
      op_b = q_r[0] ? sh_r : '0;
      sum  = {1'b0, op_a} + {1'b0, op_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      is_div <= ctl.is_div;
      acc_r  <= '0;
      q_r    <= a;
      sh_r   <= {{(PROD_W-MAG_W){1'b0}}, b};
    end else if (busy) begin
      if (is_div) begin
        if (!sum[PROD_W]) begin
          acc_r <= sum[PROD_W-1:0];
          q_r   <= {q_r[MAG_W-2:0], 1'b1};
        end else begin
          acc_r <= op_a;
          q_r   <= {q_r[MAG_W-2:0], 1'b0};
        end
      end else begin
        acc_r <= sum[PROD_W-1:0];
        q_r   <= {1'b0, q_r[MAG_W-1:1]};
        sh_r  <= {sh_r[PROD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = is_div ? {{(PROD_W-MAG_W){1'b0}}, q_r} : acc_r;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the decimal accumulator execute unit, with a cycle-free predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import daeu_pkg::*;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [ADDR_W-1:0]        address;
    logic signed [RV_W-1:0]   read_value;
  } instr_t;

  typedef struct {
    status_t                  status;
    logic                     write_valid;
    logic signed [WORD_W-1:0] write_word;
    logic                     branch_taken;
    logic [TGT_W-1:0]         branch_target;
    logic signed [WORD_W-1:0] acc;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  instr_t       instr_queue[$];
  exec_result_t pending_results[$];
  int           data_words[MEM_WORDS_DEF];
  int           acc_model;
  int           item_total;
  int           directed_total;
  int           instr_sent;
  int           mismatch_count;
  int           gap_left;
  int           stall_left;
  logic         calm = 1'b0;

  decimal_accumulator_execute_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit in_word_range(input int v);
    return v >= int'(WORD_MIN) && v <= int'(WORD_MAX);
  endfunction

  function automatic exec_result_t execute_instr(input instr_t ins);
    exec_result_t r;
    int word;
    int rv;
    int t;
    r.status        = ST_OK;
    r.write_valid   = 1'b0;
    r.write_word    = '0;
    r.branch_taken  = 1'b0;
    r.branch_target = '0;
    word = (ins.address < MEM_WORDS_DEF) ? data_words[ins.address] : 0;
    rv   = ins.read_value;
    case (ins.cmd)
      OP_READ: begin
        if (!in_word_range(rv)) r.status = ST_READ_RANGE;
        else if (ins.address < MEM_WORDS_DEF) data_words[ins.address] = rv;
      end
      OP_WRITE: begin
        r.write_valid = 1'b1;
        r.write_word  = word[WORD_W-1:0];
      end
      OP_LOAD: acc_model = word;
      OP_STORE: begin
        if (ins.address < MEM_WORDS_DEF) data_words[ins.address] = acc_model;
      end
      OP_ADD, OP_SUB, OP_MUL: begin
        if (ins.cmd == OP_ADD) t = acc_model + word;
        else if (ins.cmd == OP_SUB) t = acc_model - word;
        else t = acc_model * word;
        if (in_word_range(t)) acc_model = t;
        else r.status = ST_OVERFLOW;
      end
      OP_DIV: begin
        if (acc_model == 0) r.status = ST_DIV_ZERO;
        else acc_model = word / acc_model;
      end
      OP_BR:     r.branch_taken = 1'b1;
      OP_BRNEG:  r.branch_taken = acc_model < 0;
      OP_BRZERO: r.branch_taken = acc_model == 0;
      OP_HALT:   r.status = ST_HALT;
      default: ;
    endcase
    if (r.branch_taken) r.branch_target = ins.address;
    r.acc = acc_model[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_op();
    case ($urandom_range(0, 11))
      0:  return OP_READ;
      1:  return OP_WRITE;
      2:  return OP_LOAD;
      3:  return OP_STORE;
      4:  return OP_ADD;
      5:  return OP_SUB;
      6:  return OP_DIV;
      7:  return OP_MUL;
      8:  return OP_BR;
      9:  return OP_BRNEG;
      10: return OP_BRZERO;
      default: return OP_HALT;
    endcase
  endfunction

  function automatic int pick_addr();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return $urandom_range(0, 15);
    if (roll < 19) return $urandom_range(0, MEM_WORDS_DEF - 1);
    return $urandom_range(MEM_WORDS_DEF, 127);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: begin
        case ($urandom_range(0, 3))
          0: return 9999;
          1: return -9999;
          2: return 10000;
          default: return -10000;
        endcase
      end
      2, 3, 4: return int'($urandom_range(0, 198)) - 99;
      default: return int'($urandom_range(0, 19998)) - 9999;
    endcase
  endfunction

  function automatic string result_text(input exec_result_t r);
    return $sformatf("st=%0d wv=%0b ww=%0d bt=%0b tgt=%0d acc=%0d", r.status,
                     r.write_valid, r.write_word, r.branch_taken, r.branch_target, r.acc);
  endfunction

  task automatic push_instr(input logic [CMD_W-1:0] op, input int addr, input int rv);
    instr_t it;
    it.cmd        = op;
    it.address    = addr[ADDR_W-1:0];
    it.read_value = rv[RV_W-1:0];
    instr_queue.push_back(it);
  endtask

  task automatic report_fault(input string what, input exec_result_t want,
                              input exec_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %s, got %s", $realtime, what, result_text(want),
               result_text(got));
  endtask

  // Driver: presents queued instructions, with random gaps and a full drain at set points.
  always @(posedge clk) begin
    instr_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      instr_sent = 0;
      gap_left = 0;
      acc_model = 0;
      for (int i = 0; i < MEM_WORDS_DEF; i++) data_words[i] = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd        = s_axis_tdata[6:0];
        it.address    = s_axis_tdata[13:7];
        it.read_value = s_axis_tdata[29:14];
        pending_results.push_back(execute_instr(it));
        instr_sent++;
      end
      calm <= (instr_sent >= item_total - 200) || ((instr_sent / 150) % 3 == 2);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if ((instr_sent == directed_total || (instr_sent > 0 && instr_sent % 500 == 0))
                     && pending_results.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (instr_queue.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 3);
          s_axis_tvalid <= 1'b0;
        end else begin
          it = instr_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, it.read_value, it.address, it.cmd};
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    exec_result_t got;
    exec_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      mismatch_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status        = status_t'(m_axis_tdata[2:0]);
        got.write_valid   = m_axis_tdata[3];
        got.write_word    = m_axis_tdata[18:4];
        got.branch_taken  = m_axis_tdata[19];
        got.branch_target = m_axis_tdata[26:20];
        got.acc           = m_axis_tdata[41:27];
        if (pending_results.size() == 0) begin
          want = got;
          report_fault("unexpected result beat", want, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.write_valid !== want.write_valid ||
              got.write_word !== want.write_word || got.branch_taken !== want.branch_taken ||
              got.branch_target !== want.branch_target || got.acc !== want.acc)
            report_fault("result mismatch", want, got);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int a;
    int b;
    int c;
    logic [CMD_W-1:0] op;
    item_total = 1_000_000;
    directed_total = 0;

    // Directed part, run from the reset state.
    push_instr(OP_DIV, 5, 0);
    push_instr(OP_BRZERO, 17, 0);
    push_instr(OP_BRNEG, 18, 0);
    push_instr(OP_READ, 0, 9999);
    push_instr(OP_READ, 1, -9999);
    push_instr(OP_READ, 2, 10000);
    push_instr(OP_READ, 3, -10000);
    push_instr(OP_READ, 4, 32767);
    push_instr(OP_READ, 5, -32768);
    push_instr(OP_READ, 99, 2);
    push_instr(OP_READ, 127, 7);
    push_instr(OP_WRITE, 127, 0);
    push_instr(OP_LOAD, 0, 0);
    push_instr(OP_ADD, 99, 0);
    push_instr(OP_MUL, 1, 0);
    push_instr(OP_SUB, 99, 0);
    push_instr(OP_STORE, 6, 0);
    push_instr(OP_WRITE, 6, 0);
    push_instr(OP_LOAD, 1, 0);
    push_instr(OP_BRNEG, 0, 0);
    push_instr(OP_SUB, 99, 0);
    push_instr(OP_DIV, 0, 0);
    push_instr(OP_MUL, 1, 0);
    push_instr(OP_BR, 127, 0);
    push_instr(OP_HALT, 0, 0);
    push_instr(7'd127, 127, -1);
    directed_total = instr_queue.size();

    while (instr_queue.size() < 1650) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // A short well-formed program: fetch two operands, combine, save, show and branch.
          a = pick_addr();
          b = pick_addr();
          c = pick_addr();
          push_instr(OP_READ, a, pick_value());
          push_instr(OP_READ, b, pick_value());
          push_instr(OP_LOAD, a, pick_value());
          case ($urandom_range(0, 3))
            0: op = OP_ADD;
            1: op = OP_SUB;
            2: op = OP_MUL;
            default: op = OP_DIV;
          endcase
          push_instr(op, b, pick_value());
          push_instr(OP_STORE, c, pick_value());
          push_instr(OP_WRITE, c, pick_value());
          case ($urandom_range(0, 2))
            0: op = OP_BRNEG;
            1: op = OP_BRZERO;
            default: op = OP_BR;
          endcase
          push_instr(op, pick_addr(), pick_value());
        end
        3, 4, 5, 6, 7: begin
          push_instr(pick_op(), pick_addr(), pick_value());
        end
        default: begin
          op = CMD_W'($urandom_range(0, 127));
          push_instr(op, $urandom_range(0, 127), $urandom_range(0, 65535));
        end
      endcase
    end
    item_total = instr_queue.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (instr_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
